/* sv/dmsd_pkg.sv */
// Package for the DEX modified-UTF-8 string decoder.
// Holds the request and result types, the mode and kind codes and the UTF-8 byte encoder.
// No dependencies.
package dmsd_pkg;

    localparam logic [1:0] MODE_DATA  = 2'd0;
    localparam logic [1:0] MODE_END   = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [20:0] REPL_CP = 21'h00FFFD;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic        string_good;
        logic        length_match;
        logic [31:0] unit_total;
        logic [31:0] prefix_length;
        logic        last;
    } result_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [1:0] idx);
        logic [7:0] b;
        logic [2:0] rem;
        begin
            rem = len - 3'd1 - {1'b0, idx};
            b = 8'h80 | {2'b00, cp[5:0]};
            unique case (rem)
                3'd1: b = 8'h80 | {2'b00, cp[11:6]};
                3'd2: b = 8'h80 | {2'b00, cp[17:12]};
                default: b = 8'h80 | {2'b00, cp[5:0]};
            endcase
            if (idx == 2'd0)
            begin
                unique case (len)
                    3'd1: b = cp[7:0];
                    3'd2: b = 8'hC0 | {3'b000, cp[10:6]};
                    3'd3: b = 8'hE0 | {4'h0, cp[15:12]};
                    default: b = 8'hF0 | {5'b00000, cp[20:18]};
                endcase
            end
            return b;
        end
    endfunction

endpackage

/* sv/dmsd_front.sv */
// Front end of the string decoder: a short request queue in front of the decode engine.
// Depends on dmsd_pkg.
module dmsd_front
    import dmsd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output q_head_t head,
    input  logic    pop
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          q_mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           push, do_pop;

    assign item_ready = (cnt_reg != CW'(DEPTH));
    assign push       = item_valid && item_ready;
    assign do_pop     = pop && (cnt_reg != '0);
    assign head.valid = (cnt_reg != '0);
    assign head.item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* sv/dmsd_back.sv */
// Back end of the string decoder: prefix reader, lookahead window, piece decoder and emitter.
// Results pass through a holding register and an output register. Depends on dmsd_pkg.
module dmsd_back
    import dmsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_head_t head,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;
    localparam logic [1:0] S_FLUSH  = 2'd3;

    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [2:0] ACT_BREAK = 3'd0;
    localparam logic [2:0] ACT_END   = 3'd1;
    localparam logic [2:0] ACT_BAD   = 3'd2;
    localparam logic [2:0] ACT_CP    = 3'd3;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] prefix_reg, prefix_next;
    logic [2:0]  seen_reg, seen_next;
    logic [7:0]  win_reg [6];
    logic [7:0]  win_next [6];
    logic [2:0]  wcnt_reg, wcnt_next;
    logic [31:0] units_reg, units_next;
    logic        err_reg, err_next;
    logic        at_end_reg, at_end_next;
    logic [20:0] cp_reg, cp_next;
    logic [2:0]  len_reg, len_next;
    logic [1:0]  idx_reg, idx_next;
    result_t     pend_reg, pend_next;
    logic        pend_v_reg, pend_v_next;
    result_t     out_reg, out_next;
    logic        out_v_reg, out_v_next;

    logic        out_free, can_put, produce, flush_now;
    result_t     prod_data;

    logic [2:0]  act;
    logic [2:0]  consume;
    logic [20:0] dec_cp;
    logic        dec_two;
    logic        end_err;
    logic        c1, c2, c5, fail;
    logic [15:0] cp3;
    logic [32:0] usum;
    logic        match;
    logic [31:0] shifted;
    result_t     summary, bad_summary, byte_res;

    assign out_free = !out_v_reg || result_ready;
    assign can_put  = !pend_v_reg || out_free;
    assign result_valid = out_v_reg;
    assign result = out_reg;

    assign c1  = (win_reg[1][7:6] == 2'b10);
    assign c2  = (win_reg[2][7:6] == 2'b10);
    assign c5  = (win_reg[5][7:6] == 2'b10);
    assign cp3 = {win_reg[0][3:0], win_reg[1][5:0], win_reg[2][5:0]};
    assign fail = ((wcnt_reg >= 3'd4) && (win_reg[3] != 8'hED))
               || ((wcnt_reg >= 3'd5) && (win_reg[4][7:4] != 4'hB))
               || ((wcnt_reg >= 3'd6) && !c5);

    always_comb
    begin
        act     = ACT_BAD;
        consume = 3'd1;
        dec_cp  = REPL_CP;
        dec_two = 1'b0;
        end_err = 1'b0;
        if (wcnt_reg == 3'd0)
        begin
            act     = at_end_reg ? ACT_END : ACT_BREAK;
            end_err = at_end_reg;
        end
        else if (win_reg[0] == 8'h00)
        begin
            act = ACT_END;
        end
        else if (!win_reg[0][7])
        begin
            act    = ACT_CP;
            dec_cp = {13'd0, win_reg[0]};
        end
        else if (win_reg[0][7:5] == 3'b110)
        begin
            if (wcnt_reg < 3'd2)
            begin
                act = at_end_reg ? ACT_BAD : ACT_BREAK;
            end
            else if (c1)
            begin
                act     = ACT_CP;
                consume = 3'd2;
                dec_cp  = {10'd0, win_reg[0][4:0], win_reg[1][5:0]};
            end
        end
        else if (win_reg[0][7:4] == 4'hE)
        begin
            if (wcnt_reg >= 3'd2 && !c1)
            begin
                act = ACT_BAD;
            end
            else if (wcnt_reg < 3'd3)
            begin
                act = at_end_reg ? ACT_BAD : ACT_BREAK;
            end
            else if (!c2)
            begin
                act = ACT_BAD;
            end
            else if (cp3[15:10] == 6'b110110)
            begin
                consume = 3'd3;
                if (fail)
                begin
                    act = ACT_BAD;
                end
                else if (wcnt_reg < 3'd6)
                begin
                    act = at_end_reg ? ACT_BAD : ACT_BREAK;
                end
                else
                begin
                    act     = ACT_CP;
                    consume = 3'd6;
                    dec_two = 1'b1;
                    dec_cp  = 21'h010000
                            + {1'b0, cp3[9:0], win_reg[4][3:0], win_reg[5][5:0]};
                end
            end
            else if (cp3[15:10] == 6'b110111)
            begin
                act     = ACT_BAD;
                consume = 3'd3;
            end
            else
            begin
                act     = ACT_CP;
                consume = 3'd3;
                dec_cp  = {5'd0, cp3};
            end
        end
    end

    assign usum  = {1'b0, units_reg} + (dec_two ? 33'd2 : 33'd1);
    assign match = (units_reg == prefix_reg);

    always_comb
    begin
        summary = '0;
        summary.kind          = KIND_SUMMARY;
        summary.length_match  = match;
        summary.string_good   = match && !err_reg && !end_err;
        summary.unit_total    = units_reg;
        summary.prefix_length = prefix_reg;
        bad_summary = '0;
        bad_summary.kind = KIND_SUMMARY;
        byte_res = '0;
        byte_res.kind     = KIND_BYTE;
        byte_res.out_byte = utf8_byte(cp_reg, len_reg, idx_reg);
    end

    always_comb
    begin
        unique case (seen_reg)
            3'd0: shifted = {25'd0, head.item.data_byte[6:0]};
            3'd1: shifted = {18'd0, head.item.data_byte[6:0], 7'd0};
            3'd2: shifted = {11'd0, head.item.data_byte[6:0], 14'd0};
            3'd3: shifted = {4'd0, head.item.data_byte[6:0], 21'd0};
            default: shifted = {head.item.data_byte[3:0], 28'd0};
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        seen_next   = seen_reg;
        win_next    = win_reg;
        wcnt_next   = wcnt_reg;
        units_next  = units_reg;
        err_next    = err_reg;
        at_end_next = at_end_reg;
        cp_next     = cp_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        out_next    = out_reg;
        out_v_next  = out_v_reg;
        pop         = 1'b0;
        produce     = 1'b0;
        flush_now   = 1'b0;
        prod_data   = byte_res;

        if (out_v_reg && result_ready)
        begin
            out_v_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    priority if (head.item.mode == MODE_START)
                    begin
                        phase_next  = PH_PREFIX;
                        prefix_next = '0;
                        seen_next   = '0;
                        wcnt_next   = '0;
                        units_next  = '0;
                        err_next    = 1'b0;
                    end
                    else if (head.item.mode == MODE_DATA && phase_reg == PH_PREFIX)
                    begin
                        if (seen_reg >= 3'd4 && head.item.data_byte > 8'h0F)
                        begin
                            produce    = 1'b1;
                            prod_data  = bad_summary;
                            phase_next = PH_DONE;
                            wcnt_next  = '0;
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            prefix_next = prefix_reg | shifted;
                            seen_next   = ((seen_reg > 3'd4) ? 3'd4 : seen_reg) + 3'd1;
                            if (!head.item.data_byte[7])
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    else if (head.item.mode == MODE_DATA && phase_reg == PH_BODY)
                    begin
                        win_next[wcnt_reg] = head.item.data_byte;
                        wcnt_next   = wcnt_reg + 3'd1;
                        at_end_next = 1'b0;
                        state_next  = S_DECIDE;
                    end
                    else if (head.item.mode == MODE_END && phase_reg == PH_PREFIX)
                    begin
                        produce    = 1'b1;
                        prod_data  = bad_summary;
                        phase_next = PH_DONE;
                        wcnt_next  = '0;
                        state_next = S_FLUSH;
                    end
                    else if (head.item.mode == MODE_END && phase_reg == PH_BODY)
                    begin
                        at_end_next = 1'b1;
                        state_next  = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DECIDE:
            begin
                unique case (act)
                    ACT_BREAK:
                    begin
                        state_next = S_FLUSH;
                    end
                    ACT_END:
                    begin
                        if (can_put)
                        begin
                            produce    = 1'b1;
                            prod_data  = summary;
                            err_next   = err_reg || end_err;
                            phase_next = PH_DONE;
                            wcnt_next  = '0;
                            state_next = S_FLUSH;
                        end
                    end
                    default:
                    begin
                        cp_next  = (act == ACT_CP) ? dec_cp : REPL_CP;
                        if (act == ACT_BAD)
                        begin
                            err_next = 1'b1;
                        end
                        priority if (cp_next < 21'h80)
                        begin
                            len_next = 3'd1;
                        end
                        else if (cp_next < 21'h800)
                        begin
                            len_next = 3'd2;
                        end
                        else if (cp_next < 21'h10000)
                        begin
                            len_next = 3'd3;
                        end
                        else
                        begin
                            len_next = 3'd4;
                        end
                        idx_next   = '0;
                        units_next = usum[32] ? 32'hFFFF_FFFF : usum[31:0];
                        for (int j = 0; j < 6; j++)
                        begin
                            unique case (consume)
                                3'd1: win_next[j] = (j + 1 < 6) ? win_reg[(j + 1) % 6] : win_reg[j];
                                3'd2: win_next[j] = (j + 2 < 6) ? win_reg[(j + 2) % 6] : win_reg[j];
                                3'd3: win_next[j] = (j + 3 < 6) ? win_reg[(j + 3) % 6] : win_reg[j];
                                default: win_next[j] = win_reg[j];
                            endcase
                        end
                        wcnt_next  = wcnt_reg - consume;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (can_put)
                begin
                    produce = 1'b1;
                    if ({1'b0, idx_reg} == len_reg - 3'd1)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                if (!pend_v_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    flush_now  = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase

        if (produce)
        begin
            if (pend_v_reg)
            begin
                out_next   = pend_reg;
                out_v_next = 1'b1;
            end
            pend_next   = prod_data;
            pend_v_next = 1'b1;
        end
        if (flush_now)
        begin
            out_next      = pend_reg;
            out_next.last = 1'b1;
            out_v_next    = 1'b1;
            pend_v_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        cp_reg   <= cp_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_PREFIX;
            prefix_reg <= '0;
            seen_reg   <= '0;
            wcnt_reg   <= '0;
            units_reg  <= '0;
            err_reg    <= 1'b0;
            at_end_reg <= 1'b0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            seen_reg   <= seen_next;
            wcnt_reg   <= wcnt_next;
            units_reg  <= units_next;
            err_reg    <= err_next;
            at_end_reg <= at_end_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

endmodule

/* sv/dex_mutf8_string_decoder_core.sv */
// Top level of the DEX modified-UTF-8 to UTF-8 string decoder.
// Joins the request queue (dmsd_front) and the decode engine (dmsd_back); uses dmsd_pkg.
//
//   Channel  Handshake                    Payload
//   item     item_valid / item_ready      item_t: mode, data_byte
//   result   result_valid / result_ready  result_t: kind, out_byte, summary fields, last
//
// The engine takes one request from the queue per cycle when idle, then makes the window
// decisions, emits the output bytes and closes the request.
// An ASCII byte thus passes through the pop, two decisions, one byte and the close.
// Reset clears all control state and the queue; the lookahead bytes are not cleared.
// The queue accepts requests while it is not full, also while a result waits on a stalled output.
module dex_mutf8_string_decoder_core
    import dmsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);
    q_head_t head;
    logic    pop;

    dmsd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .head       (head),
        .pop        (pop)
    );

    dmsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
